// ----- rtl/mer_pkg.sv -----
package mer_pkg;

	// datapath operations
	typedef logic [3:0] dp_op_t;
	localparam dp_op_t DP_NOP  = 4'd0;
	localparam dp_op_t DP_LOAD = 4'd1;
	localparam dp_op_t DP_ADV  = 4'd2;
	localparam dp_op_t DP_RX2  = 4'd3;
	localparam dp_op_t DP_RY2  = 4'd4;
	localparam dp_op_t DP_INIT = 4'd5;
	localparam dp_op_t DP_UPD  = 4'd6;
	localparam dp_op_t DP_SET  = 4'd7;
	localparam dp_op_t DP_ADD4 = 4'd8;
	localparam dp_op_t DP_SUB4 = 4'd9;

	// multiplier operand pairs
	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MUL_RXRX   = 3'd0;
	localparam mul_sel_t MUL_RYRY   = 3'd1;
	localparam mul_sel_t MUL_RX2RY  = 3'd2;
	localparam mul_sel_t MUL_HXHX   = 3'd3;
	localparam mul_sel_t MUL_PRY2   = 3'd4;
	localparam mul_sel_t MUL_YMYM   = 3'd5;
	localparam mul_sel_t MUL_PRX2   = 3'd6;
	localparam mul_sel_t MUL_RX2RY2 = 3'd7;

	// advance op code of the request beat
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef struct packed {
		dp_op_t   dp_op;
		mul_sel_t mul_sel;
		logic     emit;
		logic     blank;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic zero_rad;
		logic out_free;
		logic do_switch;
	} dp_status_t;

endpackage

// ----- rtl/mer_req_if.sv -----
interface mer_req_if #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
);
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius_x;
	logic        [RADIUS_BITS-1:0] radius_y;

	modport source (
		output valid, op, center_x, center_y, radius_x, radius_y,
		input  ready
	);
	modport sink (
		input  valid, op, center_x, center_y, radius_x, radius_y,
		output ready
	);
endinterface

// ----- rtl/mer_res_if.sv -----
interface mer_res_if #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
);
	logic                          valid;
	logic                          ready;
	logic                          point_valid;
	logic signed [COORD_BITS:0]    right_x;
	logic signed [COORD_BITS:0]    left_x;
	logic signed [COORD_BITS:0]    top_y;
	logic signed [COORD_BITS:0]    bottom_y;
	logic        [RADIUS_BITS-1:0] offset_x;
	logic        [RADIUS_BITS-1:0] offset_y;
	logic                          in_region_two;
	logic                          last_point;

	modport source (
		output valid, point_valid, right_x, left_x, top_y, bottom_y,
		output offset_x, offset_y, in_region_two, last_point,
		input  ready
	);
	modport sink (
		input  valid, point_valid, right_x, left_x, top_y, bottom_y,
		input  offset_x, offset_y, in_region_two, last_point,
		output ready
	);
endinterface

// ----- rtl/midpoint_ellipse_rasterizer_core.sv -----
// advance beat: accept, decision update with result registered; the result waits while the output is not free,
// and no new beat is taken until the last is through. Region change: once per ellipse, one shared multiplier builds
// the new decision (states SW0 to SW5). Start beat: radius squares and initial decision on the multiplier (M0 to M3),
// skipped when either radius is zero
// advance with no ellipse in progress: blank result
// reset: asynchronous, active low; no ellipse in progress, no result pending
module midpoint_ellipse_rasterizer_core #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input logic       clk,
	input logic       arst_n,
	mer_req_if.sink   req,
	mer_res_if.source res
);
	import mer_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.op),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mer_dp #(
		.RADIUS_BITS (RADIUS_BITS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_center_x (req.center_x),
		.in_center_y (req.center_y),
		.in_radius_x (req.radius_x),
		.in_radius_y (req.radius_y),
		.res         (res)
	);

endmodule

// ----- rtl/mer_ctrl.sv -----
module mer_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_ready,
	input  mer_pkg::dp_status_t status,
	output mer_pkg::dp_cmd_t    cmd
);
	import mer_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_M0    = 4'd1;
	localparam logic [3:0] ST_M1    = 4'd2;
	localparam logic [3:0] ST_M2    = 4'd3;
	localparam logic [3:0] ST_M3    = 4'd4;
	localparam logic [3:0] ST_UPD   = 4'd5;
	localparam logic [3:0] ST_EMIT  = 4'd6;
	localparam logic [3:0] ST_BLANK = 4'd7;
	localparam logic [3:0] ST_SW0   = 4'd8;
	localparam logic [3:0] ST_SW1   = 4'd9;
	localparam logic [3:0] ST_SW2   = 4'd10;
	localparam logic [3:0] ST_SW3   = 4'd11;
	localparam logic [3:0] ST_SW4   = 4'd12;
	localparam logic [3:0] ST_SW5   = 4'd13;

	logic [3:0] state_q, state_n;
	logic       sw_q, sw_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sw_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			sw_q    <= sw_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		sw_n        = sw_q;
		cmd.dp_op   = DP_NOP;
		cmd.mul_sel = MUL_RXRX;
		cmd.emit    = 1'b0;
		cmd.blank   = 1'b0;
		in_ready    = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				sw_n = 1'b0;
				if (in_valid) begin
					if (in_op == OP_START) begin
						cmd.dp_op = DP_LOAD;
						state_n   = status.zero_rad ? ST_EMIT : ST_M0;
					end else if (status.active) begin
						cmd.dp_op = DP_ADV;
						state_n   = ST_UPD;
					end else begin
						state_n = ST_BLANK;
					end
				end
			end
			// squares of the radii and the initial decision term
			ST_M0: begin
				cmd.mul_sel = MUL_RXRX;
				state_n     = ST_M1;
			end
			ST_M1: begin
				cmd.dp_op   = DP_RX2;
				cmd.mul_sel = MUL_RYRY;
				state_n     = ST_M2;
			end
			ST_M2: begin
				cmd.dp_op   = DP_RY2;
				cmd.mul_sel = MUL_RX2RY;
				state_n     = ST_M3;
			end
			ST_M3: begin
				cmd.dp_op = DP_INIT;
				state_n   = ST_EMIT;
			end
			ST_UPD: begin
				cmd.dp_op = DP_UPD;
				sw_n      = status.do_switch;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = status.do_switch ? ST_SW0 : ST_IDLE;
				end else begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = sw_q ? ST_SW0 : ST_IDLE;
				end
			end
			ST_BLANK: begin
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					cmd.blank = 1'b1;
					state_n   = ST_IDLE;
				end
			end
			// region two decision: ry2*hx*hx + 4*rx2*ym*ym - 4*rx2*ry2
			ST_SW0: begin
				cmd.mul_sel = MUL_HXHX;
				state_n     = ST_SW1;
			end
			ST_SW1: begin
				cmd.mul_sel = MUL_PRY2;
				state_n     = ST_SW2;
			end
			ST_SW2: begin
				cmd.dp_op   = DP_SET;
				cmd.mul_sel = MUL_YMYM;
				state_n     = ST_SW3;
			end
			ST_SW3: begin
				cmd.mul_sel = MUL_PRX2;
				state_n     = ST_SW4;
			end
			ST_SW4: begin
				cmd.dp_op   = DP_ADD4;
				cmd.mul_sel = MUL_RX2RY2;
				state_n     = ST_SW5;
			end
			ST_SW5: begin
				cmd.dp_op = DP_SUB4;
				sw_n      = 1'b0;
				state_n   = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/mer_dp.sv -----
module mer_dp #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mer_pkg::dp_cmd_t              cmd,
	output mer_pkg::dp_status_t           status,
	input  logic signed [COORD_BITS-1:0]  in_center_x,
	input  logic signed [COORD_BITS-1:0]  in_center_y,
	input  logic        [RADIUS_BITS-1:0] in_radius_x,
	input  logic        [RADIUS_BITS-1:0] in_radius_y,
	mer_res_if.source                     res
);
	import mer_pkg::*;

	localparam int R  = RADIUS_BITS;
	localparam int C  = COORD_BITS;
	localparam int MA = 2 * R + 2;
	localparam int MB = 2 * R;
	localparam int MP = MA + MB;
	localparam int PW = 3 * R;
	localparam int DW = 4 * R + 8;
	localparam int WW = (C > R ? C : R) + 2;

	logic signed [C-1:0] cx_q, cy_q;
	logic [R-1:0]        rx_q, ry_q, x_q, y_q;
	logic [2*R-1:0]      rx2_q, ry2_q;
	logic [PW-1:0]       px_q, py_q;
	logic [DW-1:0]       d_q;
	logic [MP-1:0]       p_q;
	logic                mvx_q, mvy_q;
	logic                region_q, active_q, ov_q;

	logic [MA-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [R:0]    hx;
	logic [R-1:0]  ym;
	logic          zr, d_neg, d_zero, mvx_n, mvy_n, switch_now, out_free;
	logic [DW-1:0] d_upd, d_px, d_py, d_k;

	assign zr         = (in_radius_x == '0) || (in_radius_y == '0);
	assign d_neg      = d_q[DW-1];
	assign d_zero     = (d_q == '0);
	assign mvx_n      = region_q ? (d_neg || d_zero) : 1'b1;
	assign mvy_n      = region_q ? 1'b1 : !d_neg;
	assign switch_now = !region_q && (px_q > py_q);
	assign out_free   = !ov_q || res.ready;
	assign hx         = {x_q, 1'b1};
	assign ym         = y_q - R'(1);

	assign status.active    = active_q;
	assign status.zero_rad  = zr;
	assign status.out_free  = out_free;
	assign status.do_switch = switch_now;

	// step update of the decision from the incremental products
	assign d_px  = mvx_q ? (DW'(px_q) << 3) : '0;
	assign d_py  = mvy_q ? (DW'(py_q) << 3) : '0;
	assign d_k   = region_q ? (DW'(rx2_q) << 2) : (DW'(ry2_q) << 2);
	assign d_upd = d_q + d_px - d_py + d_k;

	always_comb begin
		case (cmd.mul_sel)
			MUL_RXRX: begin
				mul_a = MA'(rx_q);
				mul_b = MB'(rx_q);
			end
			MUL_RYRY: begin
				mul_a = MA'(ry_q);
				mul_b = MB'(ry_q);
			end
			MUL_RX2RY: begin
				mul_a = MA'(rx2_q);
				mul_b = MB'(ry_q);
			end
			MUL_HXHX: begin
				mul_a = MA'(hx);
				mul_b = MB'(hx);
			end
			MUL_PRY2: begin
				mul_a = p_q[MA-1:0];
				mul_b = ry2_q;
			end
			MUL_YMYM: begin
				mul_a = MA'(ym);
				mul_b = MB'(ym);
			end
			MUL_PRX2: begin
				mul_a = p_q[MA-1:0];
				mul_b = rx2_q;
			end
			MUL_RX2RY2: begin
				mul_a = MA'(rx2_q);
				mul_b = ry2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= MP'(mul_a) * MP'(mul_b);
		case (cmd.dp_op)
			DP_LOAD: begin
				cx_q <= in_center_x;
				cy_q <= in_center_y;
				rx_q <= in_radius_x;
				ry_q <= in_radius_y;
				x_q  <= '0;
				y_q  <= zr ? '0 : in_radius_y;
				px_q <= '0;
				d_q  <= '0;
			end
			DP_ADV: begin
				x_q   <= x_q + R'(mvx_n);
				y_q   <= y_q - R'(mvy_n);
				px_q  <= mvx_n ? px_q + PW'(ry2_q) : px_q;
				py_q  <= mvy_n ? py_q - PW'(rx2_q) : py_q;
				mvx_q <= mvx_n;
				mvy_q <= mvy_n;
			end
			DP_RX2:  rx2_q <= p_q[2*R-1:0];
			DP_RY2:  ry2_q <= p_q[2*R-1:0];
			DP_INIT: begin
				py_q <= p_q[PW-1:0];
				d_q  <= (DW'(ry2_q) << 2) - (DW'(p_q) << 2) + DW'(rx2_q);
			end
			DP_UPD:  d_q <= d_upd;
			DP_SET:  d_q <= DW'(p_q);
			DP_ADD4: d_q <= d_q + (DW'(p_q) << 2);
			DP_SUB4: d_q <= d_q - (DW'(p_q) << 2);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= 1'b0;
			active_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			case (cmd.dp_op)
				DP_LOAD: begin
					region_q <= 1'b0;
					active_q <= !zr;
				end
				DP_UPD: begin
					region_q <= region_q || switch_now;
					active_q <= (y_q != '0);
				end
				default: ;
			endcase
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// output beat register
	logic signed [WW-1:0] cx_w, cy_w;
	logic [WW-1:0]        x_w, y_w, rxs, lxs, tys, bys;
	logic                 region_out;

	assign cx_w       = WW'(cx_q);
	assign cy_w       = WW'(cy_q);
	assign x_w        = WW'(x_q);
	assign y_w        = WW'(y_q);
	assign rxs        = cx_w + x_w;
	assign lxs        = cx_w - x_w;
	assign tys        = cy_w + y_w;
	assign bys        = cy_w - y_w;
	assign region_out = region_q || ((cmd.dp_op == DP_UPD) && switch_now);

	logic                pv_q, reg2_q, last_q;
	logic signed [C:0]   rxo_q, lxo_q, tyo_q, byo_q;
	logic [R-1:0]        oxo_q, oyo_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.blank) begin
				pv_q   <= 1'b0;
				rxo_q  <= '0;
				lxo_q  <= '0;
				tyo_q  <= '0;
				byo_q  <= '0;
				oxo_q  <= '0;
				oyo_q  <= '0;
				reg2_q <= 1'b0;
				last_q <= 1'b0;
			end else begin
				pv_q   <= 1'b1;
				rxo_q  <= rxs[C:0];
				lxo_q  <= lxs[C:0];
				tyo_q  <= tys[C:0];
				byo_q  <= bys[C:0];
				oxo_q  <= x_q;
				oyo_q  <= y_q;
				reg2_q <= region_out;
				last_q <= (y_q == '0);
			end
		end
	end

	assign res.valid         = ov_q;
	assign res.point_valid   = pv_q;
	assign res.right_x       = rxo_q;
	assign res.left_x        = lxo_q;
	assign res.top_y         = tyo_q;
	assign res.bottom_y      = byo_q;
	assign res.offset_x      = oxo_q;
	assign res.offset_y      = oyo_q;
	assign res.in_region_two = reg2_q;
	assign res.last_point    = last_q;

endmodule
